/* design/psu_pkg.sv */
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types and constants for the PNG scanline unfilter block.
// ----------------------------------------------------------------------------
package psu_pkg;

  // Default row memory depth
  localparam int MAX_ROW_BYTES_DEF = 16384;

  // Configuration field widths
  localparam int BPP_W = 3;
  localparam int RB_W  = 15;

  // APB address and register index codes
  localparam int PADDR_W = 3;
  localparam logic REG_BPP      = 1'b0;
  localparam logic REG_ROW_BYTES = 1'b1;

  // Row filter type codes
  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  // Operands for the predictor stage
  typedef struct packed {
    logic [7:0] filter;
    logic [7:0] raw;
    logic [7:0] a;      // left
    logic [7:0] b;      // up
    logic [7:0] c;      // upper-left
  } pred_in_t;

  typedef struct packed {
    logic [7:0] res;
    logic       bad;
  } pred_out_t;

endpackage

/* design/psu_row_mem.sv */
// ----------------------------------------------------------------------------
// psu_row_mem
// Previous-row byte store: one write port, one registered read port, with
// a same-address bypass so a read issued on the write edge sees new data.
// ----------------------------------------------------------------------------
module psu_row_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] dout_r;
  logic       fwd_r;
  logic [7:0] fwd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, old data on collision is replaced by the bypass below
  always_ff @(posedge clk) begin
    if (rd_en) begin
      dout_r     <= mem[rd_addr];
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : dout_r;

endmodule

/* design/psu_predict.sv */
// ----------------------------------------------------------------------------
// psu_predict
// Filter predictor and reconstruction add: None, Sub, Up, Average, Paeth.
// ----------------------------------------------------------------------------
module psu_predict
  import psu_pkg::*;
(
  input  pred_in_t  pin,
  output pred_out_t pout
);

  logic signed [10:0] p, pa, pb, pc;
  logic [8:0] sum_ab;
  logic [7:0] paeth_sel;
  logic [7:0] pred;

  // Paeth distances
  always_comb begin
    p  = $signed({3'b000, pin.a}) + $signed({3'b000, pin.b}) - $signed({3'b000, pin.c});
    pa = (p > $signed({3'b000, pin.a})) ? p - $signed({3'b000, pin.a})
                                        : $signed({3'b000, pin.a}) - p;
    pb = (p > $signed({3'b000, pin.b})) ? p - $signed({3'b000, pin.b})
                                        : $signed({3'b000, pin.b}) - p;
    pc = (p > $signed({3'b000, pin.c})) ? p - $signed({3'b000, pin.c})
                                        : $signed({3'b000, pin.c}) - p;
    if (pa <= pb && pa <= pc) begin
      paeth_sel = pin.a;
    end else if (pb <= pc) begin
      paeth_sel = pin.b;
    end else begin
      paeth_sel = pin.c;
    end
  end

  // Predictor select and add
  always_comb begin
    sum_ab   = {1'b0, pin.a} + {1'b0, pin.b};
    pout.bad = 1'b0;
    case (pin.filter)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = pin.a;
      FILT_UP:    pred = pin.b;
      FILT_AVG:   pred = sum_ab[8:1];
      FILT_PAETH: pred = paeth_sel;
      default: begin
        pred     = 8'd0;
        pout.bad = 1'b1;
      end
    endcase
    pout.res = pin.raw + pred;
  end

endmodule

/* design/png_scanline_unfilter.sv */
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// Removes PNG row filters from a decompressed byte stream, one byte a cycle.
// ----------------------------------------------------------------------------
// A data byte passes the predictor stage register, then the output register.
// Throughput: one byte per cycle unless output stalls; the row memory read
//   is issued on accept and the write-back happens as the byte leaves the
//   predictor stage. Filter-type bytes are consumed and give no output.
// Reset (synchronous, rst_n low): awaits a filter byte of a first row,
//   pixel size = 1, row_bytes = 1. Row memory is not cleared.
module png_scanline_unfilter
  import psu_pkg::*;
#(
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_raw_byte,
  input  logic               in_new_image,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_pixel_byte,
  output logic               out_end_of_row,
  output logic               out_bad_filter,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW = $clog2(MAX_ROW_BYTES);
  localparam int CW = (IW + 1 > RB_W) ? IW + 1 : RB_W;

  // Configuration registers
  logic [BPP_W-1:0] bpp_r;
  logic [RB_W-1:0]  rb_r;

  // Front-end row tracking
  logic          awaiting_r;
  logic [IW-1:0] idx_r;
  logic          first_row_r;
  logic [7:0]    row_filter_r;

  // Predictor stage
  logic          s1_v_r;
  logic [IW-1:0] s1_idx_r;
  logic [7:0]    s1_raw_r;
  logic [7:0]    s1_filter_r;
  logic          s1_first_r;
  logic          s1_eor_r;

  // Row history shift registers
  logic [7:0] left_r   [4];
  logic [7:0] upleft_r [4];

  // Output register
  logic       out_v_r;
  logic [7:0] out_byte_r;
  logic       out_eor_r;
  logic       out_bad_r;

  logic          in_acc, is_filter, data_acc, s1_go, eor_f;
  logic [1:0]    bpp_m1;
  logic [CW-1:0] rb_c, next_cnt;
  logic [7:0]    mem_rd;
  logic          near_start;
  pred_in_t      pin;
  pred_out_t     pout;

  // APB register access
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_BPP:       prdata = {{(32-BPP_W){1'b0}}, bpp_r};
      REG_ROW_BYTES: prdata = {{(32-RB_W){1'b0}}, rb_r};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= BPP_W'(1);
      rb_r  <= RB_W'(1);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_BPP:       bpp_r <= pwdata[BPP_W-1:0];
        REG_ROW_BYTES: rb_r  <= pwdata[RB_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pixel size and row length
  always_comb begin
    if (bpp_r == '0) begin
      bpp_m1 = 2'd0;
    end else if (bpp_r > BPP_W'(4)) begin
      bpp_m1 = 2'd3;
    end else begin
      bpp_m1 = 2'(bpp_r - BPP_W'(1));
    end
    if (rb_r == '0) begin
      rb_c = CW'(1);
    end else if (CW'(rb_r) > CW'(MAX_ROW_BYTES)) begin
      rb_c = CW'(MAX_ROW_BYTES);
    end else begin
      rb_c = CW'(rb_r);
    end
  end

  // Handshake
  assign s1_go     = s1_v_r && (!out_v_r || out_ready);
  assign in_ready  = !s1_v_r || s1_go;
  assign in_acc    = in_valid && in_ready;
  assign is_filter = in_new_image || awaiting_r;
  assign data_acc  = in_acc && !is_filter;
  assign next_cnt  = CW'(idx_r) + CW'(1);
  assign eor_f     = next_cnt >= rb_c;

  // Row position and filter tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r   <= 1'b1;
      idx_r        <= '0;
      first_row_r  <= 1'b1;
      row_filter_r <= FILT_NONE;
    end else if (in_acc) begin
      if (is_filter) begin
        awaiting_r   <= 1'b0;
        idx_r        <= '0;
        row_filter_r <= in_raw_byte;
        if (in_new_image) begin
          first_row_r <= 1'b1;
        end
      end else if (eor_f) begin
        awaiting_r  <= 1'b1;
        first_row_r <= 1'b0;
      end else begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

  // Predictor stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (data_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_acc) begin
      s1_idx_r    <= idx_r;
      s1_raw_r    <= in_raw_byte;
      s1_filter_r <= row_filter_r;
      s1_first_r  <= first_row_r;
      s1_eor_r    <= eor_f;
    end
  end

  // Previous row store
  psu_row_mem #(
    .DEPTH (MAX_ROW_BYTES),
    .AW    (IW)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (data_acc),
    .rd_addr (idx_r),
    .rd_data (mem_rd),
    .wr_en   (s1_go),
    .wr_addr (s1_idx_r),
    .wr_data (pout.res)
  );

  // Neighbor selection: bytes before the first full pixel read as zero
  assign near_start = s1_idx_r <= IW'(bpp_m1);
  always_comb begin
    pin.filter = s1_filter_r;
    pin.raw    = s1_raw_r;
    pin.a      = near_start ? 8'd0 : left_r[bpp_m1];
    pin.b      = s1_first_r ? 8'd0 : mem_rd;
    pin.c      = near_start ? 8'd0 : upleft_r[bpp_m1];
  end

  psu_predict u_predict (
    .pin  (pin),
    .pout (pout)
  );

  // History shift on each reconstructed byte
  always_ff @(posedge clk) begin
    if (s1_go) begin
      left_r[0]   <= pout.res;
      upleft_r[0] <= pin.b;
      for (int k = 1; k < 4; k++) begin
        left_r[k]   <= left_r[k-1];
        upleft_r[k] <= upleft_r[k-1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_byte_r <= pout.res;
      out_eor_r  <= s1_eor_r;
      out_bad_r  <= pout.bad;
    end
  end

  assign out_valid      = out_v_r;
  assign out_pixel_byte = out_byte_r;
  assign out_end_of_row = out_eor_r;
  assign out_bad_filter = out_bad_r;

endmodule
